@@ rtl/fractional_feedback_delay_macros.svh @@
// Assertion macros used by the fractional feedback delay top level.
`ifndef FRACTIONAL_FEEDBACK_DELAY_MACROS_SVH
`define FRACTIONAL_FEEDBACK_DELAY_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ffd_pkg.sv @@
// Shared types and constants of the fractional feedback delay.
package ffd_pkg;

    // Fixed widths of the configuration fields.
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int WHOLE_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 16;

    // Second multiplier operand: a 16-bit gain or fraction plus a sign bit.
    localparam int MUL_B_W = 17;

    // Extra accumulator bits above the sample width.
    localparam int ACC_EXTRA = 20;

    // Unity wet level in Q1.15.
    localparam logic [GAIN_W-1:0] WET_UNITY = 16'h8000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_WHOLE    = 3'd0,
        CFG_DELAY_FRACTION = 3'd1,
        CFG_FEEDBACK_GAIN  = 3'd2,
        CFG_EXTERNAL_GAIN  = 3'd3,
        CFG_USE_EXTERNAL   = 3'd4,
        CFG_WET_GAIN       = 3'd5
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_RD0    = 13'b0000000000010,
        ST_RD1    = 13'b0000000000100,
        ST_CAP0   = 13'b0000000001000,
        ST_INTERP = 13'b0000000010000,
        ST_INT_W  = 13'b0000000100000,
        ST_FB     = 13'b0000001000000,
        ST_MIX    = 13'b0000010000000,
        ST_WR     = 13'b0000100000000,
        ST_NRD    = 13'b0001000000000,
        ST_TAP    = 13'b0010000000000,
        ST_TAP_W  = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } t_state;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic issue;
        logic shift16;
    } t_mac_ctl;

endpackage

@@ rtl/ffd_store.sv @@
// Single-port sample memory with registered read data.
module ffd_store #(
    parameter int STORE_DEPTH = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(STORE_DEPTH)-1:0] i_addr,
    input  logic [SAMPLE_BITS-1:0]         i_wdata,
    output logic [SAMPLE_BITS-1:0]         o_rdata
);

    logic [SAMPLE_BITS-1:0] r_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rdata;

    // Read-first port: the address is read every cycle and written on enable.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ffd_mac.sv @@
// Shared two-stage multiply, accumulate, round and saturate unit.
module ffd_mac #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  ffd_pkg::t_mac_ctl                                i_ctl,
    input  logic signed [SAMPLE_BITS:0]                      i_a,
    input  logic signed [ffd_pkg::MUL_B_W-1:0]               i_b,
    input  logic signed [SAMPLE_BITS+ffd_pkg::ACC_EXTRA-1:0] i_c,
    output logic                                             o_valid,
    output logic signed [SAMPLE_BITS-1:0]                    o_result
);

    localparam int ACC_W  = SAMPLE_BITS + ffd_pkg::ACC_EXTRA;
    localparam int PROD_W = SAMPLE_BITS + 1 + ffd_pkg::MUL_B_W;

    logic                       r_v1;
    logic                       r_v2;
    logic                       r_sh16;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_c;
    logic signed [SAMPLE_BITS-1:0] r_res;

    logic signed [ACC_W-1:0]       w_sum;
    logic signed [ACC_W-1:0]       w_shifted;
    logic [ACC_W-SAMPLE_BITS:0]    w_top;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    // Valid pipeline that follows the two data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    // First stage: the product and the addend are registered.
    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod <= i_a * i_b;
            r_c    <= i_c;
            r_sh16 <= i_ctl.shift16;
        end
    end

    // Second stage: accumulate, round half up, shift and saturate.
    always_comb begin
        w_sum = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod} + r_c
              + (r_sh16 ? (ACC_W'(1) << 15) : (ACC_W'(1) << 14));
        w_shifted = r_sh16 ? (w_sum >>> 16) : (w_sum >>> 15);
        w_top = w_shifted[ACC_W-1:SAMPLE_BITS-1];
        if ((&w_top) || !(|w_top)) begin
            w_sat = w_shifted[SAMPLE_BITS-1:0];
        end else if (w_shifted[ACC_W-1]) begin
            w_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // The result holds until the next operation reaches this stage.
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_res <= w_sat;
        end
    end

    assign o_valid  = r_v2;
    assign o_result = r_res;

endmodule

@@ rtl/fractional_feedback_delay.sv @@
// Top level of the fractional feedback delay: sequencer, settings and ports.
//
// For each input transaction the sequencer reads the two delay taps from the
// single-port sample store, then runs four operations (interpolation, feedback
// write value, wet/dry mix, feedback tap) through one shared pipelined
// multiplier, writes the store once and reads it once more. The input is
// stalled while the sequencer is busy. Results go to an output register, so a
// new input is taken while the previous result still waits downstream; a result
// that finds the output register full waits in the last step until it frees.
// The store needs no clearing pass after reset: a write pointer plus a wrap
// flag tell which entries were written since reset, and unwritten ones read as
// zero. Configuration is written through a simple write port; the user must
// write it only while idle, as the block itself does not enforce this.
module fractional_feedback_delay #(
    parameter int STORE_DEPTH = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ffd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_in_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_out_sample,
    output logic signed [SAMPLE_BITS-1:0]     o_feedback_tap
);

    `include "fractional_feedback_delay_macros.svh"

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int ACC_W = SAMPLE_BITS + ffd_pkg::ACC_EXTRA;
    localparam int BW    = ffd_pkg::MUL_B_W;

    // Configuration registers.
    logic [ffd_pkg::WHOLE_W-1:0]       r_dly_whole;
    logic [ffd_pkg::FRAC_W-1:0]        r_dly_frac;
    logic signed [ffd_pkg::GAIN_W-1:0] r_fb_gain;
    logic signed [ffd_pkg::GAIN_W-1:0] r_ext_gain;
    logic                              r_use_ext;
    logic [ffd_pkg::GAIN_W-1:0]        r_wet_gain;

    // Sequencer and datapath registers.
    ffd_pkg::t_state               r_state;
    ffd_pkg::t_state               n_state;
    logic [AW-1:0]                 r_wp;
    logic                          r_wrap;
    logic [AW-1:0]                 r_rd;
    logic [AW-1:0]                 r_rd1;
    logic                          r_rd_ok;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_t0;
    logic signed [SAMPLE_BITS-1:0] r_t1;
    logic signed [SAMPLE_BITS-1:0] r_d;
    logic signed [SAMPLE_BITS-1:0] r_mix;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic signed [SAMPLE_BITS-1:0] r_fb_tap;

    // Combinational signals.
    logic [AW-1:0]                 w_dw_eff;
    logic                          w_dw_zero;
    logic [AW-1:0]                 w_rd;
    logic [AW-1:0]                 w_nrd;
    logic [AW-1:0]                 w_addr;
    logic                          w_we;
    logic [SAMPLE_BITS-1:0]        w_rdata_raw;
    logic signed [SAMPLE_BITS-1:0] w_rdata;
    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_load_out;
    logic [ffd_pkg::GAIN_W-1:0]    w_wet_eff;
    logic signed [ffd_pkg::GAIN_W-1:0] w_gain_sel;
    ffd_pkg::t_mac_ctl             w_mac_ctl;
    logic signed [SAMPLE_BITS:0]   w_mac_a;
    logic signed [BW-1:0]          w_mac_b;
    logic signed [ACC_W-1:0]       w_mac_c;
    logic                          w_mac_valid;
    logic signed [SAMPLE_BITS-1:0] w_mac_res;

    // Position n samples behind pos in the circular store.
    function automatic logic [AW-1:0] f_back(input logic [AW-1:0] pos,
                                             input logic [AW-1:0] n);
        logic [AW:0] diff;
        diff = {1'b0, pos} - {1'b0, n};
        if (pos < n) begin
            diff = diff + (AW+1)'(STORE_DEPTH);
        end
        return diff[AW-1:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_whole <= '0;
            r_dly_frac  <= '0;
            r_fb_gain   <= '0;
            r_ext_gain  <= '0;
            r_use_ext   <= 1'b0;
            r_wet_gain  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ffd_pkg::CFG_DELAY_WHOLE: begin
                    r_dly_whole <= i_cfg_data[ffd_pkg::WHOLE_W-1:0];
                end
                ffd_pkg::CFG_DELAY_FRACTION: begin
                    r_dly_frac <= i_cfg_data[ffd_pkg::FRAC_W-1:0];
                end
                ffd_pkg::CFG_FEEDBACK_GAIN: begin
                    r_fb_gain <= i_cfg_data[ffd_pkg::GAIN_W-1:0];
                end
                ffd_pkg::CFG_EXTERNAL_GAIN: begin
                    r_ext_gain <= i_cfg_data[ffd_pkg::GAIN_W-1:0];
                end
                ffd_pkg::CFG_USE_EXTERNAL: begin
                    r_use_ext <= i_cfg_data[0];
                end
                ffd_pkg::CFG_WET_GAIN: begin
                    r_wet_gain <= i_cfg_data[ffd_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Settings limited to their legal ranges.
    always_comb begin
        if (32'(r_dly_whole) >= 32'(STORE_DEPTH)) begin
            w_dw_eff = AW'(STORE_DEPTH - 1);
        end else begin
            w_dw_eff = AW'(r_dly_whole);
        end
        w_dw_zero  = (w_dw_eff == '0);
        w_wet_eff  = (r_wet_gain > ffd_pkg::WET_UNITY) ? ffd_pkg::WET_UNITY : r_wet_gain;
        w_gain_sel = r_use_ext ? r_ext_gain : r_fb_gain;
    end

    // Tap positions for the current transaction and for the next one.
    assign w_rd  = f_back(r_wp, w_dw_eff);
    assign w_nrd = f_back(r_wp, w_dw_eff);

    // Handshake qualifiers.
    assign w_in_acc   = i_in_valid && (r_state == ffd_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = (r_state == ffd_pkg::ST_DONE) && w_out_free;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffd_pkg::ST_IDLE:   if (w_in_acc) n_state = ffd_pkg::ST_RD0;
            ffd_pkg::ST_RD0:    n_state = ffd_pkg::ST_RD1;
            ffd_pkg::ST_RD1:    n_state = ffd_pkg::ST_CAP0;
            ffd_pkg::ST_CAP0:   n_state = ffd_pkg::ST_INTERP;
            ffd_pkg::ST_INTERP: n_state = ffd_pkg::ST_INT_W;
            ffd_pkg::ST_INT_W:  n_state = ffd_pkg::ST_FB;
            ffd_pkg::ST_FB:     n_state = ffd_pkg::ST_MIX;
            ffd_pkg::ST_MIX:    n_state = ffd_pkg::ST_WR;
            ffd_pkg::ST_WR:     n_state = ffd_pkg::ST_NRD;
            ffd_pkg::ST_NRD:    n_state = ffd_pkg::ST_TAP;
            ffd_pkg::ST_TAP:    n_state = ffd_pkg::ST_TAP_W;
            ffd_pkg::ST_TAP_W:  n_state = ffd_pkg::ST_DONE;
            ffd_pkg::ST_DONE:   if (w_out_free) n_state = ffd_pkg::ST_IDLE;
            default:            n_state = ffd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Write pointer and wrap flag track which store entries hold data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_wrap <= 1'b0;
        end else if (r_state == ffd_pkg::ST_WR) begin
            if (32'(r_wp) == 32'(STORE_DEPTH - 1)) begin
                r_wp   <= '0;
                r_wrap <= 1'b1;
            end else begin
                r_wp <= r_wp + AW'(1);
            end
        end
    end

    // Store address selection and the written flag of the entry being read.
    always_comb begin
        case (r_state)
            ffd_pkg::ST_RD0: w_addr = r_rd;
            ffd_pkg::ST_RD1: w_addr = r_rd1;
            ffd_pkg::ST_NRD: w_addr = w_nrd;
            default:         w_addr = r_wp;
        endcase
        w_we = (r_state == ffd_pkg::ST_WR);
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_wrap || (w_addr < r_wp);
    end

    assign w_rdata = r_rd_ok ? w_rdata_raw : '0;

    ffd_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_mac_res),
        .o_rdata (w_rdata_raw)
    );

    // Capture of the input, the taps and the intermediate results.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x   <= i_in_sample;
            r_rd  <= w_rd;
            r_rd1 <= f_back(w_rd, AW'(1));
        end
        if (r_state == ffd_pkg::ST_RD1) begin
            r_t0 <= w_dw_zero ? r_x : w_rdata;
        end
        if (r_state == ffd_pkg::ST_CAP0) begin
            r_t1 <= w_rdata;
        end
        if (r_state == ffd_pkg::ST_FB) begin
            r_d <= w_mac_res;
        end
        if (r_state == ffd_pkg::ST_NRD) begin
            r_mix <= w_mac_res;
        end
    end

    // Operands of the shared unit for each step.
    always_comb begin
        w_mac_ctl = '0;
        w_mac_a   = '0;
        w_mac_b   = '0;
        w_mac_c   = '0;
        case (r_state)
            ffd_pkg::ST_INTERP: begin
                // t0 + (t1 - t0) * fraction, rounded by 2^16.
                w_mac_ctl.issue   = 1'b1;
                w_mac_ctl.shift16 = 1'b1;
                w_mac_a = {r_t1[SAMPLE_BITS-1], r_t1} - {r_t0[SAMPLE_BITS-1], r_t0};
                w_mac_b = {1'b0, r_dly_frac};
                w_mac_c = {{(ACC_W-SAMPLE_BITS-16){r_t0[SAMPLE_BITS-1]}}, r_t0, 16'b0};
            end
            ffd_pkg::ST_FB: begin
                // Store value: input plus selected gain times delayed sample.
                w_mac_ctl.issue = 1'b1;
                w_mac_a = {w_mac_res[SAMPLE_BITS-1], w_mac_res};
                w_mac_b = {w_gain_sel[ffd_pkg::GAIN_W-1], w_gain_sel};
                w_mac_c = {{(ACC_W-SAMPLE_BITS-15){r_x[SAMPLE_BITS-1]}}, r_x, 15'b0};
            end
            ffd_pkg::ST_MIX: begin
                // Mix: input + wet * (delayed - input), rounded by 2^15.
                w_mac_ctl.issue = 1'b1;
                w_mac_a = {r_d[SAMPLE_BITS-1], r_d} - {r_x[SAMPLE_BITS-1], r_x};
                w_mac_b = {1'b0, w_wet_eff};
                w_mac_c = {{(ACC_W-SAMPLE_BITS-15){r_x[SAMPLE_BITS-1]}}, r_x, 15'b0};
            end
            ffd_pkg::ST_TAP: begin
                // Feedback tap at the next read position.
                w_mac_ctl.issue = 1'b1;
                w_mac_a = {w_rdata[SAMPLE_BITS-1], w_rdata};
                w_mac_b = {r_fb_gain[ffd_pkg::GAIN_W-1], r_fb_gain};
            end
            default: begin
            end
        endcase
    end

    ffd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_a      (w_mac_a),
        .i_b      (w_mac_b),
        .i_c      (w_mac_c),
        .o_valid  (w_mac_valid),
        .o_result (w_mac_res)
    );

    // Output register for the result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= r_mix;
            r_fb_tap     <= w_mac_res;
        end
    end

    assign o_in_stall     = (r_state != ffd_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_sample   = r_out_sample;
    assign o_feedback_tap = r_fb_tap;

    // Every store write moves the write pointer on.
    `FFD_ASSERT_NEXT(a_wp_advance, r_state == ffd_pkg::ST_WR, r_wp != $past(r_wp), "write pointer did not advance after a store write")

    // Once the store has wrapped, every entry stays written.
    `FFD_ASSERT_NEXT(a_wrap_sticky, r_wrap, r_wrap, "wrap flag cleared outside reset")

    // A new result appears only from the final sequencer step.
    `FFD_ASSERT_NOW(a_out_from_done, $rose(r_out_valid), $past(r_state == ffd_pkg::ST_DONE), "output loaded outside the final step")

    // The shared unit has a result ready whenever the sequencer consumes one.
    `FFD_ASSERT_NOW(a_mac_ready, r_state == ffd_pkg::ST_FB || r_state == ffd_pkg::ST_WR || r_state == ffd_pkg::ST_NRD || r_state == ffd_pkg::ST_TAP_W, w_mac_valid || r_state == ffd_pkg::ST_TAP_W, "shared unit result not ready when used")

endmodule

@@ verif/fractional_feedback_delay_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the fractional feedback delay, with a bit-exact predictor.
module fractional_feedback_delay_tb;

    localparam int STORE_DEPTH    = 131072;
    localparam int SAMPLE_BITS    = 24;
    localparam int PTR_W          = $clog2(STORE_DEPTH);
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 128;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_REPORTS    = 10;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // One output transaction: mixed sample and feedback tap.
    typedef struct packed {
        t_sample mix;
        t_sample tap;
    } t_delay_out;

    // Expected result typed in by hand, or taken from the predictor.
    typedef struct packed {
        logic       fixed;
        t_delay_out res;
    } t_typed_out;

    // Full register set of the delay line.
    typedef struct packed {
        logic [ffd_pkg::WHOLE_W-1:0]       whole;
        logic [ffd_pkg::FRAC_W-1:0]        frac;
        logic signed [ffd_pkg::GAIN_W-1:0] fb_gain;
        logic signed [ffd_pkg::GAIN_W-1:0] ext_gain;
        logic                              use_ext;
        logic [ffd_pkg::GAIN_W-1:0]        wet;
    } t_delay_cfg;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic [2:0] cfg_sel;
        t_sample    sample;
        logic       fixed;
        t_sample    mix;
        t_sample    tap;
    } t_dir_row;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [ffd_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [ffd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    t_sample                        in_sample = '0;
    logic                           out_stall = 1'b0;
    logic                           in_stall;
    logic                           out_valid;
    t_sample                        out_sample;
    t_sample                        feedback_tap;

    // Predictor state.
    t_sample               delay_mem [STORE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr  = '0;
    t_delay_cfg            mdl_cfg = '0;

    t_delay_out            pending_outputs [$];
    t_typed_out            typed_outputs [$];
    t_delay_out            want;
    int                    mismatches   = 0;
    int                    quiet_cycles = 0;
    int                    idle_pct     = 0;
    int                    stall_pct    = 0;
    int                    hold_count   = 0;
    logic                  long_hold_en = 1'b0;
    logic                  in_stall_seen;

    t_delay_cfg            dir_cfgs [5];
    t_dir_row              dir_rows [21];

    fractional_feedback_delay #(
        .STORE_DEPTH(STORE_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_sample   (in_sample),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_sample  (out_sample),
        .o_feedback_tap(feedback_tap)
    );

    always #1 clk = ~clk;

    // Round half up by 2^s, with floor division for negative values.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic t_sample saturate(input longint v);
        if (v > longint'(S_MAX)) return S_MAX;
        if (v < longint'(S_MIN)) return S_MIN;
        return t_sample'(v);
    endfunction

    // Interpolate the two taps, write the store, mix and form the feedback tap; advances the predictor.
    function automatic t_delay_out predict_delay_line(input t_sample x_in);
        longint           x, t0, t1, f, d, g, w;
        logic [PTR_W-1:0] rd, rd1, nrd;
        t_delay_out       r;
        x   = x_in;
        f   = longint'(mdl_cfg.frac);
        rd  = wr_ptr - mdl_cfg.whole;
        rd1 = rd - 1'b1;
        t0  = (mdl_cfg.whole == '0) ? x : longint'(delay_mem[rd]);
        t1  = longint'(delay_mem[rd1]);
        if (mdl_cfg.whole == '0 && mdl_cfg.frac == '0)
            d = x;
        else
            d = round_shift(t0 * (65536 - f) + t1 * f, 16);
        g = mdl_cfg.use_ext ? longint'($signed(mdl_cfg.ext_gain))
                            : longint'($signed(mdl_cfg.fb_gain));
        delay_mem[wr_ptr] = saturate(x + round_shift(g * d, 15));
        w = (mdl_cfg.wet > ffd_pkg::WET_UNITY) ? longint'(ffd_pkg::WET_UNITY)
                                               : longint'(mdl_cfg.wet);
        r.mix  = saturate(round_shift(w * d + (32768 - w) * x, 15));
        wr_ptr = wr_ptr + 1'b1;
        nrd    = wr_ptr - mdl_cfg.whole;
        r.tap  = saturate(round_shift(longint'($signed(mdl_cfg.fb_gain))
                                      * longint'(delay_mem[nrd]), 15));
        return r;
    endfunction

    // Gains favor the two extremes.
    function automatic logic [ffd_pkg::GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Delays are mostly short so that the taps reach samples already written.
    function automatic t_delay_cfg random_settings();
        t_delay_cfg s;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            s.whole = ffd_pkg::WHOLE_W'($urandom_range(0, 16));
        else if (pick < 8)
            s.whole = ffd_pkg::WHOLE_W'($urandom_range(17, 1500));
        else if (pick < 9)
            s.whole = $urandom_range(0, 1) ? ffd_pkg::WHOLE_W'(STORE_DEPTH - 1)
                                           : ffd_pkg::WHOLE_W'(1);
        else
            s.whole = ffd_pkg::WHOLE_W'($urandom_range(0, STORE_DEPTH - 1));
        if ($urandom_range(0, 7) == 0)
            s.frac = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            s.frac = 16'($urandom);
        s.fb_gain  = random_gain();
        s.ext_gain = random_gain();
        s.use_ext  = 1'($urandom);
        case ($urandom_range(0, 7))
            0:       s.wet = 16'h0000;
            1:       s.wet = ffd_pkg::WET_UNITY;
            2:       s.wet = 16'($urandom_range(32769, 65535));
            default: s.wet = 16'($urandom_range(0, 32768));
        endcase
        return s;
    endfunction

    // Write all six registers on consecutive edges; spare data bits are random.
    task automatic write_settings(input t_delay_cfg s);
        cfg_we   <= 1'b1;
        cfg_idx  <= ffd_pkg::CFG_DELAY_WHOLE;
        cfg_data <= s.whole;
        @(posedge clk);
        cfg_idx  <= ffd_pkg::CFG_DELAY_FRACTION;
        cfg_data <= {1'($urandom), s.frac};
        @(posedge clk);
        cfg_idx  <= ffd_pkg::CFG_FEEDBACK_GAIN;
        cfg_data <= {1'($urandom), s.fb_gain};
        @(posedge clk);
        cfg_idx  <= ffd_pkg::CFG_EXTERNAL_GAIN;
        cfg_data <= {1'($urandom), s.ext_gain};
        @(posedge clk);
        cfg_idx  <= ffd_pkg::CFG_USE_EXTERNAL;
        cfg_data <= {16'($urandom), s.use_ext};
        @(posedge clk);
        cfg_idx  <= ffd_pkg::CFG_WET_GAIN;
        cfg_data <= {1'($urandom), s.wet};
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Stop offering, wait for every expected output, then let the sequencer go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one input transaction after an optional random gap and hold it until taken.
    task automatic send_sample(input t_sample s, input logic fixed, input t_delay_out res);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
        end
        typed_outputs.push_back({fixed, res});
        in_valid  <= 1'b1;
        in_sample <= s;
        @(posedge clk);
        while (in_stall_seen) @(posedge clk);
    endtask

    // The stall output only moves at rising edges, so its mid-cycle value is the one
    // that the next rising edge sees.
    always @(negedge clk) in_stall_seen <= in_stall;

    // Receiver: random stalls, plus one long hold counted here.
    always @(posedge clk) begin
        if (long_hold_en && hold_count < LONG_HOLD) begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
            if (!long_hold_en) hold_count <= 0;
        end
    end

    // Track register writes, predict each accepted input and check each output.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                case (ffd_pkg::t_cfg_idx'(cfg_idx))
                    ffd_pkg::CFG_DELAY_WHOLE:
                        mdl_cfg.whole = cfg_data[ffd_pkg::WHOLE_W-1:0];
                    ffd_pkg::CFG_DELAY_FRACTION:
                        mdl_cfg.frac = cfg_data[ffd_pkg::FRAC_W-1:0];
                    ffd_pkg::CFG_FEEDBACK_GAIN:
                        mdl_cfg.fb_gain = cfg_data[ffd_pkg::GAIN_W-1:0];
                    ffd_pkg::CFG_EXTERNAL_GAIN:
                        mdl_cfg.ext_gain = cfg_data[ffd_pkg::GAIN_W-1:0];
                    ffd_pkg::CFG_USE_EXTERNAL:
                        mdl_cfg.use_ext = cfg_data[0];
                    ffd_pkg::CFG_WET_GAIN:
                        mdl_cfg.wet = cfg_data[ffd_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                want = predict_delay_line(in_sample);
                if (typed_outputs[0].fixed) want = typed_outputs[0].res;
                void'(typed_outputs.pop_front());
                pending_outputs.push_back(want);
            end
            if (out_valid && !out_stall) begin
                if (pending_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected output: out_sample %0d feedback_tap %0d",
                                 out_sample, feedback_tap);
                end else begin
                    want = pending_outputs.pop_front();
                    if (want.mix !== out_sample || want.tap !== feedback_tap) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"Mismatch: out_sample exp %0d got %0d, ",
                                      "feedback_tap exp %0d got %0d"},
                                     want.mix, out_sample, want.tap, feedback_tap);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transaction or register write happens for too long.
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         cur_cfg;
        t_sample    s;
        t_delay_cfg cfg;

        for (int i = 0; i < STORE_DEPTH; i++) delay_mem[i] = '0;

        // Directed settings: reset values; wet above unity with zero delay; longest
        // delay; zero whole delay with a half fraction; one-sample delay at full scale.
        dir_cfgs[0] = '0;
        dir_cfgs[1] = '{whole: 17'd0, frac: 16'h0000, fb_gain: 16'h7FFF,
                        ext_gain: 16'h8000, use_ext: 1'b0, wet: 16'hFFFF};
        dir_cfgs[2] = '{whole: 17'd131071, frac: 16'h0000, fb_gain: 16'h8000,
                        ext_gain: 16'h7FFF, use_ext: 1'b1, wet: ffd_pkg::WET_UNITY};
        dir_cfgs[3] = '{whole: 17'd0, frac: 16'h8000, fb_gain: 16'h8000,
                        ext_gain: 16'h7FFF, use_ext: 1'b1, wet: 16'h4000};
        dir_cfgs[4] = '{whole: 17'd1, frac: 16'hFFFF, fb_gain: 16'h7FFF,
                        ext_gain: 16'h8000, use_ext: 1'b0, wet: ffd_pkg::WET_UNITY};

        // With zero delay and zero feedback the output is the input and the tap is zero.
        // At the longest delay both taps are still unwritten, so everything reads zero.
        dir_rows = '{
            '{3'd0, S_MAX,        1'b1, S_MAX,        24'sd0},
            '{3'd0, S_MIN,        1'b1, S_MIN,        24'sd0},
            '{3'd0, 24'sd0,       1'b1, 24'sd0,       24'sd0},
            '{3'd0, -24'sd1,      1'b1, -24'sd1,      24'sd0},
            '{3'd0, 24'sd1,       1'b1, 24'sd1,       24'sd0},
            '{3'd0, 24'sh555555,  1'b1, 24'sh555555,  24'sd0},
            '{3'd0, -24'sh555556, 1'b1, -24'sh555556, 24'sd0},
            '{3'd1, S_MAX,        1'b1, S_MAX,        24'sd0},
            '{3'd1, S_MIN,        1'b1, S_MIN,        24'sd0},
            '{3'd1, 24'sh123456,  1'b1, 24'sh123456,  24'sd0},
            '{3'd2, S_MAX,        1'b1, 24'sd0,       24'sd0},
            '{3'd2, S_MIN,        1'b1, 24'sd0,       24'sd0},
            '{3'd3, S_MAX,        1'b0, 24'sd0,       24'sd0},
            '{3'd3, S_MIN,        1'b0, 24'sd0,       24'sd0},
            '{3'd3, 24'sh400000,  1'b0, 24'sd0,       24'sd0},
            '{3'd3, -24'sd1,      1'b0, 24'sd0,       24'sd0},
            '{3'd4, S_MAX,        1'b0, 24'sd0,       24'sd0},
            '{3'd4, S_MAX,        1'b0, 24'sd0,       24'sd0},
            '{3'd4, S_MAX,        1'b0, 24'sd0,       24'sd0},
            '{3'd4, S_MIN,        1'b0, 24'sd0,       24'sd0},
            '{3'd4, S_MIN,        1'b0, 24'sd0,       24'sd0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: change settings only between groups, once the block is idle.
        cur_cfg = 0;
        foreach (dir_rows[i]) begin
            if (int'(dir_rows[i].cfg_sel) != cur_cfg) begin
                settle();
                cur_cfg = dir_rows[i].cfg_sel;
                write_settings(dir_cfgs[cur_cfg]);
            end
            send_sample(dir_rows[i].sample, dir_rows[i].fixed,
                        {dir_rows[i].mix, dir_rows[i].tap});
        end

        // Random part: each phase drains, picks new settings and an idling pattern.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            long_hold_en = 1'b0;
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 88; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            if (p == 0)
                cfg = '{whole: 17'd1, frac: 16'hFFFF, fb_gain: 16'h7FFF,
                        ext_gain: 16'h8000, use_ext: 1'b1, wet: 16'h0000};
            else if (p == 1)
                cfg = '{whole: 17'd0, frac: 16'h0000, fb_gain: 16'h8000,
                        ext_gain: 16'h7FFF, use_ext: 1'b0, wet: 16'hFFFF};
            else
                cfg = random_settings();
            write_settings(cfg);
            // The receiver holds off while inputs keep coming, so the block backs up.
            long_hold_en = (p == 4);
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0:       s = S_MAX;
                    1:       s = S_MIN;
                    2:       s = t_sample'(int'($urandom_range(0, 8)) - 4);
                    default: s = t_sample'($urandom);
                endcase
                send_sample(s, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
